// ===== design/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the block buffer cache tag store: request and
// result payloads, slot entry layout, opcodes, status codes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int DEF_SLOTS = 32;

    localparam int DEV_W   = 5;
    localparam int BLK_W   = 27;
    localparam int REFS_W  = 8;
    localparam int STAMP_W = 32;
    localparam int PORT_W  = 5;

    localparam logic [REFS_W-1:0] REFS_MAX = {REFS_W{1'b1}};

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOFREE    = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_COMMIT
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [DEV_W-1:0]   device;
        logic [BLK_W-1:0]   block_number;
        logic [PORT_W-1:0]  slot_in;
        logic [STAMP_W-1:0] now;
    } in_t;

    typedef struct packed {
        logic [PORT_W-1:0] slot_out;
        logic              hit;
        logic              needs_read;
        status_t           status;
    } out_t;

    typedef struct packed {
        logic [DEV_W-1:0]   device;
        logic [BLK_W-1:0]   block;
        logic [REFS_W-1:0]  refs;
        logic [STAMP_W-1:0] stamp;
        logic               loaded;
    } entry_t;

    typedef struct packed {
        logic start;
        logic scan_rd;
        logic slot_rd;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic is_get;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

// ===== design/block_buffer_cache_lru.sv =====
// ----------------------------------------------------------------------------
// block_buffer_cache_lru
// Tag store of a disk block buffer cache with least-recently-released
// replacement.
// ----------------------------------------------------------------------------
// One request is handled at a time. A get reads every slot once through the
// single read port of the slot memory, one slot per cycle; release, pin and
// unpin read one slot. The result sits in an output register, so a new
// request is accepted while the previous result still waits; a commit waits
// only if that register is still full. No clearing pass follows reset:
// per-slot valid bits make unwritten slots read as all-zero tags.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru
    import bbc_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    cmd_t cmd;
    sts_t sts;

    bbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bbc_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while busy");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free)
        else $error("result overwritten before transfer");

    a_nofree_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == STAT_NOFREE))
            |-> ((out_data.slot_out == '0) && !out_data.hit && !out_data.needs_read))
        else $error("no-free result carries a slot");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.hit) |-> (out_data.status == STAT_OK))
        else $error("hit with error status");

endmodule

// ===== design/bbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbc_ctrl
// Controller of the tag store: sequences request capture, the slot scan or
// single slot read, and the commit of the updated entry and the result.
// ----------------------------------------------------------------------------
module bbc_ctrl
    import bbc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (!sts.is_get || sts.scan_last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            S_ISSUE:
            begin
                cmd.scan_rd = sts.is_get;
                cmd.slot_rd = !sts.is_get;
            end
            S_WAIT:
            begin
            end
            S_COMMIT:
            begin
                cmd.commit = sts.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== design/bbc_datapath.sv =====
// ----------------------------------------------------------------------------
// bbc_datapath
// Slot memory with per-slot valid bits, request register, scan tracking of
// the first tag match and the oldest unreferenced slot, entry update logic
// and the result register.
// ----------------------------------------------------------------------------
module bbc_datapath
    import bbc_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
)
(
    input  logic clk,
    input  logic rst_n,
    input  in_t  in_data,
    input  cmd_t cmd,
    output sts_t sts,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

    entry_t mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;

    entry_t rdata_reg;
    logic   rvalid_reg;
    entry_t rentry;

    in_t req_reg;

    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] ridx_reg;
    logic              scan_vld_reg;

    logic               found_reg;
    logic [SLOT_W-1:0]  hit_idx_reg;
    logic [REFS_W-1:0]  hit_refs_reg;
    logic [STAMP_W-1:0] hit_stamp_reg;
    logic               hit_loaded_reg;

    logic               have_reg;
    logic [SLOT_W-1:0]  vic_idx_reg;
    logic [STAMP_W-1:0] vic_stamp_reg;

    logic              out_valid_reg;
    out_t              out_data_reg;

    logic              re;
    logic [SLOT_W-1:0] raddr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
    out_t              res;

    logic match;
    logic free;
    logic in_range;

    assign rentry   = rvalid_reg ? rdata_reg : '0;
    assign match    = (rentry.device == req_reg.device) && (rentry.block == req_reg.block_number);
    assign free     = (rentry.refs == '0);
    assign in_range = int'(req_reg.slot_in) < SLOTS;

    assign re    = cmd.scan_rd || cmd.slot_rd;
    assign raddr = cmd.scan_rd ? idx_reg : SLOT_W'(req_reg.slot_in);

    assign sts.is_get    = (req_reg.op == OP_GET);
    assign sts.scan_last = (idx_reg == LAST_IDX);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            ridx_reg     <= '0;
            scan_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            have_reg     <= 1'b0;
        end
        else
        begin
            scan_vld_reg <= cmd.scan_rd;
            if (cmd.start)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                have_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    idx_reg  <= idx_reg + 1'b1;
                    ridx_reg <= idx_reg;
                end
                if (scan_vld_reg)
                begin
                    if (match && !found_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (free && (!have_reg || (rentry.stamp < vic_stamp_reg)))
                    begin
                        have_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_vld_reg && match && !found_reg)
        begin
            hit_idx_reg    <= ridx_reg;
            hit_refs_reg   <= rentry.refs;
            hit_stamp_reg  <= rentry.stamp;
            hit_loaded_reg <= rentry.loaded;
        end
        if (scan_vld_reg && free && (!have_reg || (rentry.stamp < vic_stamp_reg)))
        begin
            vic_idx_reg   <= ridx_reg;
            vic_stamp_reg <= rentry.stamp;
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = SLOT_W'(req_reg.slot_in);
        wdata = rentry;
        res   = '0;
        if (sts.is_get)
        begin
            wdata.device = req_reg.device;
            wdata.block  = req_reg.block_number;
            wdata.loaded = 1'b1;
            if (found_reg)
            begin
                we           = cmd.commit;
                waddr        = hit_idx_reg;
                wdata.refs   = (hit_refs_reg == REFS_MAX) ? hit_refs_reg
                                                           : hit_refs_reg + 1'b1;
                wdata.stamp  = hit_stamp_reg;
                res.slot_out = PORT_W'(hit_idx_reg);
                res.hit      = 1'b1;
                res.needs_read = !hit_loaded_reg;
                res.status   = STAT_OK;
            end
            else if (have_reg)
            begin
                we           = cmd.commit;
                waddr        = vic_idx_reg;
                wdata.refs   = REFS_W'(1);
                wdata.stamp  = vic_stamp_reg;
                res.slot_out = PORT_W'(vic_idx_reg);
                res.needs_read = 1'b1;
                res.status   = STAT_OK;
            end
            else
            begin
                res.status = STAT_NOFREE;
            end
        end
        else
        begin
            res.slot_out = req_reg.slot_in;
            res.status   = STAT_OK;
            if (in_range)
            begin
                if (req_reg.op == OP_PIN)
                begin
                    we         = cmd.commit;
                    wdata.refs = (rentry.refs == REFS_MAX) ? rentry.refs
                                                           : rentry.refs + 1'b1;
                end
                else if (rentry.refs == '0)
                begin
                    res.status = STAT_UNDERFLOW;
                end
                else
                begin
                    we         = cmd.commit;
                    wdata.refs = rentry.refs - 1'b1;
                    if ((req_reg.op == OP_RELEASE) && (rentry.refs == REFS_W'(1)))
                    begin
                        wdata.stamp = req_reg.now;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg <= res;
        end
    end

endmodule
